// ===== rtl/core/assert_macros.svh =====
// assertion helpers included by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked check, off while reset is held
`define RMQ_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// clocked check that also holds during reset
`define RMQ_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== rtl/core/rmq_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package rmq_pkg;

  localparam int ROT_WIDTH = 16;
  localparam int POS_WIDTH = 32;
  localparam int FRAC_BITS = ROT_WIDTH - 2;
  // branch vector element, holds one + 2*mkk - trace without overflow
  localparam int VEC_W     = ROT_WIDTH + 3;
  // normalized magnitude width, largest lands in [2^29, 2^30)
  localparam int MAG_BITS  = 30;
  localparam int NORM_TOP  = MAG_BITS - 1;
  localparam int SUM_W     = 2 * MAG_BITS + 2;
  localparam int ROOT_W    = SUM_W / 2;
  localparam int QUO_W     = FRAC_BITS + 1;
  localparam int NUM_W     = MAG_BITS + QUO_W;
  localparam int SHIFT_W   = $clog2(VEC_W);

  localparam logic signed [VEC_W-1:0] ONE_VEC  = VEC_W'(2 ** FRAC_BITS);
  localparam logic [QUO_W-1:0]        ONE_QUO  = QUO_W'(2 ** FRAC_BITS);
  localparam logic [ROT_WIDTH-1:0]    ONE_ROT  = ROT_WIDTH'(2 ** FRAC_BITS);

  typedef logic signed [ROT_WIDTH-1:0] rot_t;
  typedef logic signed [POS_WIDTH-1:0] pos_t;

  typedef struct packed {
    rot_t rot_00;
    rot_t rot_01;
    rot_t rot_02;
    rot_t rot_10;
    rot_t rot_11;
    rot_t rot_12;
    rot_t rot_20;
    rot_t rot_21;
    rot_t rot_22;
    pos_t trans_x;
    pos_t trans_y;
    pos_t trans_z;
  } rmq_in_t;

  typedef struct packed {
    pos_t pos_x;
    pos_t pos_y;
    pos_t pos_z;
    rot_t quat_w;
    rot_t quat_x;
    rot_t quat_y;
    rot_t quat_z;
    logic used_identity;
  } rmq_out_t;

  typedef struct packed {
    pos_t x;
    pos_t y;
    pos_t z;
  } rmq_pos_t;

  function automatic logic signed [VEC_W-1:0] rot_ext(input rot_t v);
    return VEC_W'(v);
  endfunction

endpackage

`default_nettype wire

// ===== rtl/core/rotation_matrix_to_quaternion.sv =====
// throughput: one request per cycle unless the output stalls; a 54-stage pipeline where every stage takes one request
// most of the depth is the 31-stage square root and the 15-stage divider, one bit each
// a stalled output freezes every stage, so in_stall follows out_valid and out_stall
// reset: synchronous active-low rst_n clears all stage valid bits, data regs are not reset
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module rotation_matrix_to_quaternion (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire rmq_pkg::rmq_in_t  in_data,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output rmq_pkg::rmq_out_t      out_data
);

  import rmq_pkg::*;

  localparam int RB = ROOT_W;
  localparam int QB = QUO_W;

  // global advance: every stage moves unless the output holds a request that is stalled
  logic adv;
  logic out_vld_r;
  rmq_out_t out_data_r;

  assign adv       = !(out_vld_r && out_stall);
  assign in_stall  = !adv;
  assign out_valid = out_vld_r;
  assign out_data  = out_data_r;

  // ---------------------------------------------------------------------------
  // stage a: trace, branch pick, scaled quaternion vector
  // ---------------------------------------------------------------------------
  logic signed [VEC_W-1:0] m [0:8];
  logic signed [VEC_W-1:0] trace;
  logic signed [VEC_W-1:0] v_nxt [0:3];

  logic                    a_vld_r;
  logic [3:0][VEC_W-1:0]   a_v_r;
  rmq_pos_t                a_pos_r;

  always_comb begin
    m[0] = rot_ext(in_data.rot_00);
    m[1] = rot_ext(in_data.rot_01);
    m[2] = rot_ext(in_data.rot_02);
    m[3] = rot_ext(in_data.rot_10);
    m[4] = rot_ext(in_data.rot_11);
    m[5] = rot_ext(in_data.rot_12);
    m[6] = rot_ext(in_data.rot_20);
    m[7] = rot_ext(in_data.rot_21);
    m[8] = rot_ext(in_data.rot_22);
    trace = m[0] + m[4] + m[8];
    // strict compares: a tie on the diagonal falls to the later branch
    priority if (trace > 0) begin
      v_nxt[0] = ONE_VEC + trace;
      v_nxt[1] = m[7] - m[5];
      v_nxt[2] = m[2] - m[6];
      v_nxt[3] = m[3] - m[1];
    end else if (m[0] > m[4] && m[0] > m[8]) begin
      v_nxt[0] = m[7] - m[5];
      v_nxt[1] = ONE_VEC + (m[0] <<< 1) - trace;
      v_nxt[2] = m[1] + m[3];
      v_nxt[3] = m[2] + m[6];
    end else if (m[4] > m[8]) begin
      v_nxt[0] = m[2] - m[6];
      v_nxt[1] = m[1] + m[3];
      v_nxt[2] = ONE_VEC + (m[4] <<< 1) - trace;
      v_nxt[3] = m[5] + m[7];
    end else begin
      v_nxt[0] = m[3] - m[1];
      v_nxt[1] = m[2] + m[6];
      v_nxt[2] = m[5] + m[7];
      v_nxt[3] = ONE_VEC + (m[8] <<< 1) - trace;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_vld_r <= 1'b0;
    end else if (adv) begin
      a_vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < 4; i++) a_v_r[i] <= v_nxt[i];
      a_pos_r <= '{x: in_data.trans_x, y: in_data.trans_y, z: in_data.trans_z};
    end
  end

  // ---------------------------------------------------------------------------
  // stage b: sign and magnitude, largest magnitude
  // ---------------------------------------------------------------------------
  logic [3:0][VEC_W-1:0] mag_nxt;
  logic [VEC_W-1:0]      max_nxt;

  logic                  b_vld_r;
  logic [3:0][VEC_W-1:0] b_mag_r;
  logic [VEC_W-1:0]      b_max_r;
  logic [3:0]            b_neg_r;
  rmq_pos_t              b_pos_r;

  always_comb begin
    max_nxt = '0;
    for (int i = 0; i < 4; i++) begin
      mag_nxt[i] = a_v_r[i][VEC_W-1] ? (VEC_W'(0) - a_v_r[i]) : a_v_r[i];
      if (mag_nxt[i] > max_nxt) max_nxt = mag_nxt[i];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_vld_r <= 1'b0;
    end else if (adv) begin
      b_vld_r <= a_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      b_mag_r <= mag_nxt;
      b_max_r <= max_nxt;
      for (int i = 0; i < 4; i++) b_neg_r[i] <= a_v_r[i][VEC_W-1];
      b_pos_r <= a_pos_r;
    end
  end

  // ---------------------------------------------------------------------------
  // stage c: leading-one position of the largest magnitude
  // ---------------------------------------------------------------------------
  logic [SHIFT_W-1:0]    lead_nxt;

  logic                  c_vld_r;
  logic [3:0][VEC_W-1:0] c_mag_r;
  logic [SHIFT_W-1:0]    c_lead_r;
  logic [3:0]            c_neg_r;
  rmq_pos_t              c_pos_r;

  always_comb begin
    lead_nxt = '0;
    for (int i = 0; i < VEC_W; i++) begin
      if (b_max_r[i]) lead_nxt = SHIFT_W'(i);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      c_vld_r <= 1'b0;
    end else if (adv) begin
      c_vld_r <= b_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      c_mag_r  <= b_mag_r;
      c_lead_r <= lead_nxt;
      c_neg_r  <= b_neg_r;
      c_pos_r  <= b_pos_r;
    end
  end

  // ---------------------------------------------------------------------------
  // stage d: common shift, mag * 2^29 >> lead puts the largest in [2^29, 2^30)
  // a right shift truncates, a left shift is exact
  // ---------------------------------------------------------------------------
  logic [VEC_W+NORM_TOP-1:0] wide [0:3];

  logic                     d_vld_r;
  logic [3:0][MAG_BITS-1:0] d_mag_r;
  logic [3:0]               d_neg_r;
  rmq_pos_t                 d_pos_r;

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      wide[i] = {c_mag_r[i], NORM_TOP'(0)} >> c_lead_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      d_vld_r <= 1'b0;
    end else if (adv) begin
      d_vld_r <= c_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < 4; i++) d_mag_r[i] <= wide[i][MAG_BITS-1:0];
      d_neg_r <= c_neg_r;
      d_pos_r <= c_pos_r;
    end
  end

  // ---------------------------------------------------------------------------
  // stage e: squares, one 30x30 multiplier per component
  // ---------------------------------------------------------------------------
  logic                         e_vld_r;
  logic [3:0][2*MAG_BITS-1:0]   e_sq_r;
  logic [3:0][MAG_BITS-1:0]     e_mag_r;
  logic [3:0]                   e_neg_r;
  rmq_pos_t                     e_pos_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      e_vld_r <= 1'b0;
    end else if (adv) begin
      e_vld_r <= d_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < 4; i++) e_sq_r[i] <= d_mag_r[i] * d_mag_r[i];
      e_mag_r <= d_mag_r;
      e_neg_r <= d_neg_r;
      e_pos_r <= d_pos_r;
    end
  end

  // ---------------------------------------------------------------------------
  // square root pipeline: entry 0 holds the sum of squares, each stage
  // settles one root bit from the top pair of remaining sum bits
  // ---------------------------------------------------------------------------
  logic                     sq_vld_r  [0:RB];
  logic [SUM_W-1:0]         sq_sum_r  [0:RB];
  logic [RB+1:0]            sq_rem_r  [0:RB];
  logic [RB-1:0]            sq_root_r [0:RB];
  logic [3:0][MAG_BITS-1:0] sq_mag_r  [0:RB];
  logic [3:0]               sq_neg_r  [0:RB];
  rmq_pos_t                 sq_pos_r  [0:RB];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sq_vld_r[0] <= 1'b0;
    end else if (adv) begin
      sq_vld_r[0] <= e_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      sq_sum_r[0]  <= SUM_W'(e_sq_r[0]) + SUM_W'(e_sq_r[1])
                    + SUM_W'(e_sq_r[2]) + SUM_W'(e_sq_r[3]);
      sq_rem_r[0]  <= '0;
      sq_root_r[0] <= '0;
      sq_mag_r[0]  <= e_mag_r;
      sq_neg_r[0]  <= e_neg_r;
      sq_pos_r[0]  <= e_pos_r;
    end
  end

  for (genvar k = 0; k < RB; k++) begin : g_sqrt
    localparam int J = RB - 1 - k;
    logic [RB+3:0] t_rem;
    logic [RB+3:0] t_trial;
    logic          ge;

    always_comb begin
      t_rem   = {sq_rem_r[k], sq_sum_r[k][2*J+1 -: 2]};
      t_trial = {2'b00, sq_root_r[k], 2'b01};
      ge      = (t_rem >= t_trial);
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        sq_vld_r[k+1] <= 1'b0;
      end else if (adv) begin
        sq_vld_r[k+1] <= sq_vld_r[k];
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        sq_rem_r[k+1]  <= ge ? (RB+2)'(t_rem - t_trial) : (RB+2)'(t_rem);
        sq_root_r[k+1] <= {sq_root_r[k][RB-2:0], ge};
        sq_sum_r[k+1]  <= sq_sum_r[k];
        sq_mag_r[k+1]  <= sq_mag_r[k];
        sq_neg_r[k+1]  <= sq_neg_r[k];
        sq_pos_r[k+1]  <= sq_pos_r[k];
      end
    end
  end

  // ---------------------------------------------------------------------------
  // divider: entry 0 forms mag * 2^F + floor(r/2), then one quotient bit a stage
  // ---------------------------------------------------------------------------
  logic                   dv_vld_r [0:QB];
  logic [RB-1:0]          dv_r_r   [0:QB];
  logic                   dv_rz_r  [0:QB];
  logic [3:0][RB-1:0]     dv_rem_r [0:QB];
  logic [3:0][QB-1:0]     dv_low_r [0:QB];
  logic [3:0][QB-1:0]     dv_q_r   [0:QB];
  logic [3:0]             dv_neg_r [0:QB];
  rmq_pos_t               dv_pos_r [0:QB];

  logic [NUM_W-1:0]       num [0:3];

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      num[i] = NUM_W'({sq_mag_r[RB][i], FRAC_BITS'(0)}) + NUM_W'(sq_root_r[RB] >> 1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dv_vld_r[0] <= 1'b0;
    end else if (adv) begin
      dv_vld_r[0] <= sq_vld_r[RB];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      dv_r_r[0]  <= sq_root_r[RB];
      dv_rz_r[0] <= (sq_root_r[RB] == '0);
      for (int i = 0; i < 4; i++) begin
        dv_rem_r[0][i] <= RB'(num[i][NUM_W-1:QB]);
        dv_low_r[0][i] <= num[i][QB-1:0];
      end
      dv_q_r[0]   <= '0;
      dv_neg_r[0] <= sq_neg_r[RB];
      dv_pos_r[0] <= sq_pos_r[RB];
    end
  end

  for (genvar k = 0; k < QB; k++) begin : g_div
    localparam int B = QB - 1 - k;
    logic [RB:0] t_rem [0:3];
    logic [3:0]  ge;

    always_comb begin
      for (int i = 0; i < 4; i++) begin
        t_rem[i] = {dv_rem_r[k][i], dv_low_r[k][i][B]};
        ge[i]    = (t_rem[i] >= {1'b0, dv_r_r[k]});
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        dv_vld_r[k+1] <= 1'b0;
      end else if (adv) begin
        dv_vld_r[k+1] <= dv_vld_r[k];
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        for (int i = 0; i < 4; i++) begin
          dv_rem_r[k+1][i] <= ge[i] ? RB'(t_rem[i] - {1'b0, dv_r_r[k]}) : RB'(t_rem[i]);
          dv_q_r[k+1][i]   <= QB'({dv_q_r[k][i], ge[i]});
        end
        dv_low_r[k+1] <= dv_low_r[k];
        dv_r_r[k+1]   <= dv_r_r[k];
        dv_rz_r[k+1]  <= dv_rz_r[k];
        dv_neg_r[k+1] <= dv_neg_r[k];
        dv_pos_r[k+1] <= dv_pos_r[k];
      end
    end
  end

  // ---------------------------------------------------------------------------
  // output register: saturate to one, apply sign, identity when the root is zero
  // ---------------------------------------------------------------------------
  logic [QB-1:0]        q_sat [0:3];
  logic [ROT_WIDTH-1:0] q_val [0:3];
  rmq_out_t             out_data_nxt;

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      q_sat[i] = (dv_q_r[QB][i] > ONE_QUO) ? ONE_QUO : dv_q_r[QB][i];
      q_val[i] = dv_neg_r[QB][i] ? (ROT_WIDTH'(0) - ROT_WIDTH'(q_sat[i]))
                                 : ROT_WIDTH'(q_sat[i]);
    end
    out_data_nxt.pos_x = dv_pos_r[QB].x;
    out_data_nxt.pos_y = dv_pos_r[QB].y;
    out_data_nxt.pos_z = dv_pos_r[QB].z;
    if (dv_rz_r[QB]) begin
      out_data_nxt.quat_w        = ONE_ROT;
      out_data_nxt.quat_x        = '0;
      out_data_nxt.quat_y        = '0;
      out_data_nxt.quat_z        = '0;
      out_data_nxt.used_identity = 1'b1;
    end else begin
      out_data_nxt.quat_w        = q_val[0];
      out_data_nxt.quat_x        = q_val[1];
      out_data_nxt.quat_y        = q_val[2];
      out_data_nxt.quat_z        = q_val[3];
      out_data_nxt.used_identity = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (adv) begin
      out_vld_r <= dv_vld_r[QB];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_data_r <= out_data_nxt;
    end
  end

  // ---------------------------------------------------------------------------
  // checks
  // ---------------------------------------------------------------------------
  // a nonzero root of a sum whose largest square is at least 2^58 is at least 2^29
  `RMQ_ASSERT(a_root_range, dv_vld_r[0] && !dv_rz_r[0] |-> (dv_r_r[0][RB-1] || dv_r_r[0][RB-2]), "root below normalized range")
  // the fallback always carries the identity quaternion
  `RMQ_ASSERT(a_identity, out_vld_r && out_data_r.used_identity |-> (out_data_r.quat_w == ONE_ROT && out_data_r.quat_x == '0 && out_data_r.quat_y == '0 && out_data_r.quat_z == '0), "fallback without identity")
  // quat_w is within plus or minus one
  `RMQ_ASSERT(a_quat_bound, out_vld_r |-> ($signed(out_data_r.quat_w) <= $signed(ONE_ROT) && $signed(out_data_r.quat_w) >= -$signed(ONE_ROT)), "quat_w beyond one")
  // a finished request moves into the output register when the pipe advances
  `RMQ_ASSERT(a_drain, $past(adv) && $past(dv_vld_r[QB]) |-> out_vld_r, "result lost at the output")

endmodule

`default_nettype wire
